// ===== rtl/lmbcm_pkg.sv =====
// shared constants for the led matrix bcm scan driver
// panel geometry and derived widths; no dependencies
`default_nettype none

package lmbcm_pkg;

   localparam int COLUMNS    = 32;
   localparam int ROWS       = 16;
   localparam int PLANE_BITS = 8;

   localparam int HALF_ROWS = ROWS / 2;

   localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W = $clog2(ROWS);
   localparam int HR_W  = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;

   // stores are addressed as {row, column}
   localparam int DRAW_AW    = ROW_W + COL_W;
   localparam int DRAW_DEPTH = 2 ** DRAW_AW;
   localparam int DISP_AW    = HR_W + COL_W;
   localparam int DISP_DEPTH = 2 ** DISP_AW;

   localparam int PIX_W = 24;

   localparam logic [15:0] BASE_PERIOD_RESET = 16'd256;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_FILL  = 2'd1,
      ACT_SWAP  = 2'd2,
      ACT_TICK  = 2'd3
   } action_type;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_FILL  = 6'b000100,
      ST_SWAP  = 6'b001000,
      ST_FETCH = 6'b010000,
      ST_SEND  = 6'b100000
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/lmbcm_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`default_nettype none

module lmbcm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 512,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/led_matrix_bcm_scan_driver.sv =====
// top level of the split-row led matrix bcm scan driver
// uses lmbcm_pkg and lmbcm_ram (drawing store, upper and lower display halves)
`default_nettype none

// Request beats carry an action in tuser: pixel write, fill, swap or timer tick.
// Pixel writes and ticks that do not end the display interval are taken while
// idle and keep req_tready high. Fill and swap walk the drawing store one entry
// per cycle and hold req_tready low until the walk ends; swap reads the drawing
// store and writes the display halves in the following cycle. A tick that ends
// the interval emits COLUMNS response beats, each column a display read and then
// a send that holds while rsp_tready is low. After reset a clearing pass zeroes
// all stores with req_tready low; csr writes are taken at any time.

module led_matrix_bcm_scan_driver
   import lmbcm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [7:0] x_pos, [15:8] y_pos, [23:16] red, [31:24] green, [39:32] blue
   input  wire logic [39:0] req_tdata,
   // [1:0] action
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] latch, [3:1] row_addr, [8:4] column, [9] red_top, [10] green_top,
   // [11] blue_top, [12] red_bottom, [13] green_bottom, [14] blue_bottom, [15] zero
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_wen,
   input  wire logic [15:0] csr_wdata
);

   state_type        state_ff, state_in;
   logic [ROW_W-1:0] sy_ff, sy_in;
   logic [COL_W-1:0] sx_ff, sx_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [PIX_W-1:0] fill_ff, fill_in;
   logic             cp_valid_ff, cp_valid_in;
   logic             cp_zero_ff, cp_zero_in;
   logic [ROW_W-1:0] cp_y_ff, cp_y_in;
   logic [COL_W-1:0] cp_x_ff, cp_x_in;
   logic [2:0]       scan_row_ff, scan_row_in;
   logic [2:0]       scan_bit_ff, scan_bit_in;
   logic [2:0]       shift_ff, shift_in;
   logic [2:0]       shown_ff, shown_in;
   logic [23:0]      tick_ff, tick_in;
   logic [15:0]      base_ff, base_in;

   logic               draw_we, draw_re;
   logic [DRAW_AW-1:0] draw_waddr;
   logic [PIX_W-1:0]   draw_wdata, draw_rdata;
   logic               top_we, bot_we, disp_re;
   logic [DISP_AW-1:0] top_waddr, bot_waddr, disp_raddr;
   logic [PIX_W-1:0]   cp_data, top_rdata, bot_rdata;

   action_type  req_action;
   logic [7:0]  x_pos, y_pos;
   logic [PIX_W-1:0] req_colour;
   logic        accept;
   logic        sweep_last, col_last;
   logic [23:0] limit;
   logic [3:0]  bit_inc, row_inc;
   logic [7:0]  col_wide;

   assign req_action = action_type'(req_tuser);
   assign x_pos      = req_tdata[7:0];
   assign y_pos      = req_tdata[15:8];
   assign req_colour = {req_tdata[23:16], req_tdata[31:24], req_tdata[39:32]};

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign sweep_last = (sy_ff == ROW_W'(ROWS - 1)) && (sx_ff == COL_W'(COLUMNS - 1));
   assign col_last   = (col_ff == COL_W'(COLUMNS - 1));
   assign limit      = 24'({8'd0, base_ff} << shift_ff);
   assign bit_inc    = {1'b0, scan_bit_ff} + 4'd1;
   assign row_inc    = {1'b0, scan_row_ff} + 4'd1;

   // copy stage: write the entry read from the drawing store last cycle
   assign cp_data   = cp_zero_ff ? '0 : draw_rdata;
   assign top_waddr = {HR_W'(cp_y_ff), cp_x_ff};
   assign bot_waddr = {HR_W'(cp_y_ff - ROW_W'(HALF_ROWS)), cp_x_ff};
   assign top_we    = cp_valid_ff && (cp_y_ff < ROW_W'(HALF_ROWS));
   assign bot_we    = cp_valid_ff && !(cp_y_ff < ROW_W'(HALF_ROWS)) &&
                      ((ROW_W + 1)'(cp_y_ff) < (ROW_W + 1)'(2 * HALF_ROWS));

   assign disp_re    = (state_ff == ST_FETCH);
   assign disp_raddr = {HR_W'(scan_row_ff), col_ff};

   always_comb begin
      state_in    = state_ff;
      sy_in       = sy_ff;
      sx_in       = sx_ff;
      col_in      = col_ff;
      fill_in     = fill_ff;
      cp_valid_in = 1'b0;
      cp_zero_in  = cp_zero_ff;
      cp_y_in     = cp_y_ff;
      cp_x_in     = cp_x_ff;
      scan_row_in = scan_row_ff;
      scan_bit_in = scan_bit_ff;
      shift_in    = shift_ff;
      shown_in    = shown_ff;
      tick_in     = tick_ff;
      base_in     = csr_wen ? csr_wdata : base_ff;
      draw_we     = 1'b0;
      draw_re     = 1'b0;
      draw_waddr  = {sy_ff, sx_ff};
      draw_wdata  = fill_ff;

      // sweep counter wraps back to zero on its last entry
      if ((state_ff == ST_CLEAR) || (state_ff == ST_FILL) || (state_ff == ST_SWAP)) begin
         if (sweep_last) begin
            sy_in    = '0;
            sx_in    = '0;
            state_in = ST_IDLE;
         end else if (sx_ff == COL_W'(COLUMNS - 1)) begin
            sx_in = '0;
            sy_in = sy_ff + ROW_W'(1);
         end else begin
            sx_in = sx_ff + COL_W'(1);
         end
      end

      case (state_ff)
         ST_CLEAR: begin
            draw_we     = 1'b1;
            draw_wdata  = '0;
            cp_valid_in = 1'b1;
            cp_zero_in  = 1'b1;
            cp_y_in     = sy_ff;
            cp_x_in     = sx_ff;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_WRITE: begin
                     if ((x_pos < 8'(COLUMNS)) && (y_pos < 8'(ROWS))) begin
                        draw_we    = 1'b1;
                        draw_waddr = {ROW_W'(y_pos), COL_W'(x_pos)};
                        draw_wdata = req_colour;
                     end
                  end
                  ACT_FILL: begin
                     fill_in  = req_colour;
                     state_in = ST_FILL;
                  end
                  ACT_SWAP: begin
                     state_in = ST_SWAP;
                  end
                  ACT_TICK: begin
                     if (tick_ff < limit) begin
                        tick_in = tick_ff + 24'd1;
                     end else begin
                        tick_in  = '0;
                        shown_in = scan_row_ff;
                        shift_in = scan_bit_ff;
                        if (bit_inc >= 4'(PLANE_BITS)) begin
                           scan_bit_in = '0;
                           scan_row_in = (row_inc >= 4'(HALF_ROWS)) ? 3'd0 : row_inc[2:0];
                        end else begin
                           scan_bit_in = bit_inc[2:0];
                        end
                        col_in   = '0;
                        state_in = ST_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            draw_we = 1'b1;
         end
         ST_SWAP: begin
            draw_re     = 1'b1;
            cp_valid_in = 1'b1;
            cp_zero_in  = 1'b0;
            cp_y_in     = sy_ff;
            cp_x_in     = sx_ff;
         end
         ST_FETCH: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (rsp_tready) begin
               if (col_last) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + COL_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         sy_ff       <= '0;
         sx_ff       <= '0;
         col_ff      <= '0;
         cp_valid_ff <= 1'b0;
         scan_row_ff <= '0;
         scan_bit_ff <= '0;
         shift_ff    <= '0;
         tick_ff     <= '0;
         base_ff     <= BASE_PERIOD_RESET;
      end else begin
         state_ff    <= state_in;
         sy_ff       <= sy_in;
         sx_ff       <= sx_in;
         col_ff      <= col_in;
         cp_valid_ff <= cp_valid_in;
         scan_row_ff <= scan_row_in;
         scan_bit_ff <= scan_bit_in;
         shift_ff    <= shift_in;
         tick_ff     <= tick_in;
         base_ff     <= base_in;
      end
      fill_ff    <= fill_in;
      cp_zero_ff <= cp_zero_in;
      cp_y_ff    <= cp_y_in;
      cp_x_ff    <= cp_x_in;
      shown_ff   <= shown_in;
   end

   lmbcm_ram #(.WIDTH(PIX_W), .DEPTH(DRAW_DEPTH)) u_draw (
      .clock   (clock),
      .wr_en   (draw_we),
      .wr_addr (draw_waddr),
      .wr_data (draw_wdata),
      .rd_en   (draw_re),
      .rd_addr ({sy_ff, sx_ff}),
      .rd_data (draw_rdata)
   );

   lmbcm_ram #(.WIDTH(PIX_W), .DEPTH(DISP_DEPTH)) u_disp_top (
      .clock   (clock),
      .wr_en   (top_we),
      .wr_addr (top_waddr),
      .wr_data (cp_data),
      .rd_en   (disp_re),
      .rd_addr (disp_raddr),
      .rd_data (top_rdata)
   );

   lmbcm_ram #(.WIDTH(PIX_W), .DEPTH(DISP_DEPTH)) u_disp_bot (
      .clock   (clock),
      .wr_en   (bot_we),
      .wr_addr (bot_waddr),
      .wr_data (cp_data),
      .rd_en   (disp_re),
      .rd_addr (disp_raddr),
      .rd_data (bot_rdata)
   );

   // read data holds while the beat stalls since no new read is issued
   logic       latch_bit;
   logic [2:0] row_addr;
   logic [7:0] red_t, green_t, blue_t, red_b, green_b, blue_b;

   assign latch_bit = (col_ff == '0);
   assign row_addr  = latch_bit ? shown_ff : 3'd0;
   assign col_wide  = 8'(col_ff);
   assign red_t     = top_rdata[23:16];
   assign green_t   = top_rdata[15:8];
   assign blue_t    = top_rdata[7:0];
   assign red_b     = bot_rdata[23:16];
   assign green_b   = bot_rdata[15:8];
   assign blue_b    = bot_rdata[7:0];

   assign rsp_tvalid = (state_ff == ST_SEND);
   assign rsp_tlast  = col_last;
   assign rsp_tdata  = {1'b0,
                        blue_b[scan_bit_ff], green_b[scan_bit_ff], red_b[scan_bit_ff],
                        blue_t[scan_bit_ff], green_t[scan_bit_ff], red_t[scan_bit_ff],
                        col_wide[4:0], row_addr, latch_bit};

endmodule

`default_nettype wire

// ===== tb/lmbcm_tb_pkg.sv =====
`timescale 1ns / 1ps
// scoreboard for the led matrix bcm scan driver testbench: predicts the scan beats
// each request beat causes and checks response beats in order; depends on lmbcm_pkg

package lmbcm_tb_pkg;
   import lmbcm_pkg::*;

   localparam int PANEL_CELLS = ROWS * COLUMNS;

   typedef struct packed {
      logic       latch;
      logic [2:0] row_addr;
      logic [4:0] column;
      logic       red_top;
      logic       green_top;
      logic       blue_top;
      logic       red_bottom;
      logic       green_bottom;
      logic       blue_bottom;
      logic       last;
   } scan_beat_type;

   class bcm_scan_board;
      logic [23:0] draw_px [PANEL_CELLS];
      logic [23:0] shown_px [PANEL_CELLS];
      logic [2:0]  scan_row;
      logic [2:0]  scan_bit;
      logic [2:0]  hold_shift;
      logic [23:0] tick_count;
      logic [15:0] base_period;
      logic [HALF_ROWS-1:0] rows_shown;
      scan_beat_type pending_beats [$];
      int unsigned errors;
      int unsigned beats_checked;
      int unsigned n_write, n_offpanel, n_fill, n_clear, n_swap, n_tick, n_fire;

      function new();
         foreach (draw_px[i]) begin
            draw_px[i]  = '0;
            shown_px[i] = '0;
         end
         scan_row    = '0;
         scan_bit    = '0;
         hold_shift  = '0;
         tick_count  = '0;
         base_period = BASE_PERIOD_RESET;
         rows_shown  = '0;
      endfunction

      function void set_period(logic [15:0] value);
         base_period = value;
      endfunction

      // advance the block state for one accepted request beat
      function void apply_request(action_type act, logic [39:0] data);
         logic [7:0]  x;
         logic [7:0]  y;
         logic [23:0] color;
         logic [23:0] span;
         logic [23:0] top_px;
         logic [23:0] bot_px;
         logic [2:0]  shown_row;
         scan_beat_type beat;
         x     = data[7:0];
         y     = data[15:8];
         color = {data[23:16], data[31:24], data[39:32]};
         case (act)
            ACT_WRITE: begin
               n_write++;
               if (x < COLUMNS && y < ROWS) draw_px[int'(y) * COLUMNS + int'(x)] = color;
               else n_offpanel++;
            end
            ACT_FILL: begin
               n_fill++;
               if (color == '0) n_clear++;
               foreach (draw_px[i]) draw_px[i] = color;
            end
            ACT_SWAP: begin
               n_swap++;
               shown_px = draw_px;
            end
            default: begin
               n_tick++;
               span = 24'(base_period) << hold_shift;
               if (tick_count < span) begin
                  tick_count = tick_count + 24'd1;
               end else begin
                  n_fire++;
                  tick_count = '0;
                  shown_row  = scan_row;
                  rows_shown[shown_row] = 1'b1;
                  hold_shift = scan_bit;
                  // bit plane first, then row
                  if (scan_bit == 3'(PLANE_BITS - 1)) begin
                     scan_bit = '0;
                     scan_row = (scan_row == 3'(HALF_ROWS - 1)) ? 3'd0 : scan_row + 3'd1;
                  end else begin
                     scan_bit = scan_bit + 3'd1;
                  end
                  for (int c = 0; c < COLUMNS; c++) begin
                     top_px = shown_px[int'(scan_row) * COLUMNS + c];
                     bot_px = shown_px[(int'(scan_row) + HALF_ROWS) * COLUMNS + c];
                     beat.latch        = (c == 0);
                     beat.row_addr     = (c == 0) ? shown_row : 3'd0;
                     beat.column       = 5'(c);
                     beat.red_top      = top_px[16 + scan_bit];
                     beat.green_top    = top_px[8 + scan_bit];
                     beat.blue_top     = top_px[scan_bit];
                     beat.red_bottom   = bot_px[16 + scan_bit];
                     beat.green_bottom = bot_px[8 + scan_bit];
                     beat.blue_bottom  = bot_px[scan_bit];
                     beat.last         = (c == COLUMNS - 1);
                     pending_beats.push_back(beat);
                  end
               end
            end
         endcase
      endfunction

      function string beat_text(scan_beat_type b);
         return $sformatf("latch=%0b row=%0d col=%0d top=%b%b%b bottom=%b%b%b last=%0b",
                          b.latch, b.row_addr, b.column, b.red_top, b.green_top, b.blue_top,
                          b.red_bottom, b.green_bottom, b.blue_bottom, b.last);
      endfunction

      function void check_beat(logic [15:0] tdata, logic tlast);
         scan_beat_type got;
         scan_beat_type want;
         got.latch        = tdata[0];
         got.row_addr     = tdata[3:1];
         got.column       = tdata[8:4];
         got.red_top      = tdata[9];
         got.green_top    = tdata[10];
         got.blue_top     = tdata[11];
         got.red_bottom   = tdata[12];
         got.green_bottom = tdata[13];
         got.blue_bottom  = tdata[14];
         got.last         = tlast;
         if (pending_beats.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response beat: %s", beat_text(got));
            return;
         end
         want = pending_beats.pop_front();
         beats_checked++;
         if (got.latch !== want.latch || got.row_addr !== want.row_addr ||
             got.column !== want.column || got.red_top !== want.red_top ||
             got.green_top !== want.green_top || got.blue_top !== want.blue_top ||
             got.red_bottom !== want.red_bottom || got.green_bottom !== want.green_bottom ||
             got.blue_bottom !== want.blue_bottom || got.last !== want.last) begin
            errors++;
            if (errors <= 10)
               $display("beat %0d mismatch: expected %s, got %s",
                        beats_checked, beat_text(want), beat_text(got));
         end
      endfunction

      function void summary();
         $display("covered %0d pixel writes (%0d off panel), %0d fills (%0d clears), %0d swaps, %0d ticks",
                  n_write, n_offpanel, n_fill, n_clear, n_swap, n_tick);
         $display("%0d scan lines fired over rows %b, %0d response beats checked, %0d errors",
                  n_fire, rows_shown, beats_checked, errors);
      endfunction
   endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// top of the led matrix bcm scan driver testbench: clock, reset, request driver,
// stalling response sink and monitor; depends on lmbcm_pkg and lmbcm_tb_pkg

module tb;
   import lmbcm_pkg::*;
   import lmbcm_tb_pkg::*;

   localparam int SETTLE_CYCLES = ROWS * COLUMNS + 32;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int LONG_HOLD     = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = ACT_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wen    = 1'b0;
   logic [15:0] csr_wdata  = '0;

   bcm_scan_board board;
   int          burst_left   = 0;
   bit          hold_req     = 1'b0;
   int          hold_left    = 0;
   int          pattern_left = 0;
   logic [15:0] stall_pattern = 16'hffff;
   logic [3:0]  pattern_pos  = '0;

   led_matrix_bcm_scan_driver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   // response sink: a rotating stall pattern, plus one long hold on request
   always @(posedge clock) begin
      if (hold_req) begin
         hold_req  = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : (16'($urandom) | 16'h0101);
            pattern_left  = $urandom_range(16, 96);
         end
         pattern_left--;
         rsp_tready <= stall_pattern[pattern_pos];
         pattern_pos++;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_beat(rsp_tdata, rsp_tlast);
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("led_matrix_bcm_scan_driver test failed");
      $finish;
   end

   function automatic logic [39:0] pixel_data(logic [7:0] x, logic [7:0] y,
                                              logic [7:0] r, logic [7:0] g, logic [7:0] b);
      return {b, g, r, y, x};
   endfunction

   // offer one request beat, in bursts with random gaps; returns on the accepting edge
   task automatic send_beat(input action_type act, input logic [39:0] data);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.apply_request(act, data);
   endtask

   // stop offering, wait for every expected beat, then let a fill or swap finish
   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (board.pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_period(input logic [15:0] value);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      board.set_period(value);
      csr_wen <= 1'b0;
   endtask

   task automatic random_request();
      action_type  act;
      logic [39:0] data;
      int          pick;
      pick = $urandom_range(0, 99);
      data = {8'($urandom), 32'($urandom)};
      if (pick < 45) begin
         act = ACT_WRITE;
         if ($urandom_range(0, 9) != 0) begin
            data[7:0]  = 8'($urandom_range(0, COLUMNS - 1));
            data[15:8] = 8'($urandom_range(0, ROWS - 1));
         end
      end else if (pick < 48) begin
         act = ACT_FILL;
         if ($urandom_range(0, 1) == 0) data[39:16] = '0;
      end else if (pick < 55) begin
         act = ACT_SWAP;
      end else begin
         act = ACT_TICK;
      end
      send_beat(act, data);
   endtask

   initial begin : stimulus
      int items;
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // corners, both halves, off-panel writes and a swap, then ticks at the reset period
      send_beat(ACT_WRITE, pixel_data(8'd0, 8'd0, 8'hff, 8'h00, 8'h80));
      send_beat(ACT_WRITE, pixel_data(8'd31, 8'd15, 8'h00, 8'hff, 8'h01));
      send_beat(ACT_WRITE, pixel_data(8'd31, 8'd7, 8'h55, 8'haa, 8'hff));
      send_beat(ACT_WRITE, pixel_data(8'd0, 8'd8, 8'haa, 8'h55, 8'h00));
      send_beat(ACT_WRITE, pixel_data(8'd32, 8'd0, 8'hff, 8'hff, 8'hff));
      send_beat(ACT_WRITE, pixel_data(8'd0, 8'd16, 8'hff, 8'hff, 8'hff));
      send_beat(ACT_WRITE, pixel_data(8'd255, 8'd255, 8'hff, 8'hff, 8'hff));
      send_beat(ACT_SWAP, '0);
      repeat (3) send_beat(ACT_TICK, '0);

      drain();
      write_period(16'hffff);
      repeat (2) send_beat(ACT_TICK, '1);

      // dropping the period mid-interval ends it on the next tick
      drain();
      write_period(16'd0);
      send_beat(ACT_TICK, '0);
      send_beat(ACT_TICK, '0);
      send_beat(ACT_FILL, pixel_data(8'd0, 8'd0, 8'hff, 8'hff, 8'hff));
      send_beat(ACT_SWAP, '0);
      send_beat(ACT_TICK, '0);
      send_beat(ACT_FILL, '0);
      send_beat(ACT_TICK, '0);
      send_beat(ACT_SWAP, '0);
      send_beat(ACT_TICK, '0);
      send_beat(ACT_WRITE, pixel_data(8'd1, 8'd1, 8'h81, 8'h42, 8'h24));
      send_beat(ACT_SWAP, '0);

      for (int p = 0; p < 5; p++) begin
         drain();
         case (p)
            0: write_period(16'd1);
            1: write_period(16'd0);
            2: write_period(16'($urandom_range(1, 8)));
            3: write_period(16'd2);
            default: write_period(16'd1);
         endcase
         items = (p == 1) ? 100 : ((p == 2) ? 50 : 60);
         for (int i = 0; i < items; i++) begin
            // every tick fires here, so a long sink hold backs up into the request side
            if (p == 1 && i == 8) hold_req = 1'b1;
            random_request();
         end
      end

      drain();
      board.summary();
      if (board.errors == 0 && board.pending_beats.size() == 0)
         $display("led_matrix_bcm_scan_driver test passed");
      else
         $display("led_matrix_bcm_scan_driver test failed");
      $finish;
   end

endmodule
